@@ rtl/rsalc_pkg.sv @@
// Package: shared types and constants for the RSA letter cipher.
package rsalc_pkg;

  localparam logic [7:0] CharA    = 8'h41;
  localparam logic [7:0] CharZ    = 8'h5A;
  localparam logic [7:0] CharZero = 8'h30;
  localparam int unsigned AlphaLen = 26;

  typedef enum logic [1:0] {
    REG_MODULUS = 2'd0,
    REG_PUB_EXP = 2'd1,
    REG_PRV_EXP = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic        kind;
    logic        bad;
    logic [15:0] base;
    logic [15:0] expo;
    logic [15:0] modulus;
  } job_t;

endpackage

@@ rtl/rsalc_front.sv @@
// Front end: classify a word and form the exponentiation job.
module rsalc_front #(
  parameter int MOD_BITS = 16
) (
  input  logic               kind,
  input  logic [7:0]         letter_code,
  input  logic [15:0]        cipher_in,
  input  logic [15:0]        modulus,
  input  logic [15:0]        public_exponent,
  input  logic [15:0]        private_exponent,
  output rsalc_pkg::job_t    job
);

  logic        is_letter;
  logic [15:0] mask;
  logic [7:0]  idx;

  always_comb begin
    mask      = (MOD_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << MOD_BITS) - 32'd1);
    is_letter = (letter_code >= rsalc_pkg::CharA) && (letter_code <= rsalc_pkg::CharZ);
    idx       = letter_code - rsalc_pkg::CharA + 8'd1;
    job.kind    = kind;
    job.modulus = modulus & mask;
    if (kind) begin
      job.bad  = 1'b0;
      job.base = cipher_in & mask;
      job.expo = private_exponent;
    end else begin
      job.bad  = !is_letter;
      job.base = {8'd0, idx};
      job.expo = public_exponent;
    end
  end

endmodule

@@ rtl/rsalc_queue.sv @@
// Two-entry job queue between front and back.
module rsalc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  rsalc_pkg::job_t      din,
  input  logic                 pop,
  output rsalc_pkg::job_t      dout,
  output logic                 not_empty,
  output logic                 full
);

  rsalc_pkg::job_t mem [2];
  logic            wptr;
  logic            rptr;
  logic [1:0]      count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign dout      = mem[rptr];
  assign not_empty = (count != 2'd0);
  assign full      = (count == 2'd2);

endmodule

@@ rtl/rsalc_back.sv @@
// Back end: square-and-multiply modular exponentiation with a bit-serial remainder unit.
module rsalc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               avail,
  input  rsalc_pkg::job_t    job,
  output logic               take,
  output logic               done,
  output logic [15:0]        result_value,
  output logic [7:0]         plain_char,
  output logic               bad_symbol
);

  typedef enum logic [1:0] {
    S_IDLE, S_PROD, S_RED, S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    OP_BASE, OP_SQR, OP_MUL
  } op_t;

  state_t          state;
  op_t             op;
  rsalc_pkg::job_t cur;
  logic [15:0]     acc;
  logic [15:0]     base;
  logic [3:0]      bitpos;
  logic [31:0]     num;
  logic [15:0]     rem;
  logic [4:0]      rcnt;
  logic [16:0]     trial;
  logic [15:0]     rem_next;

  // Shift in one dividend bit, subtract the modulus when it fits.
  always_comb begin
    trial    = {rem, num[31]};
    rem_next = (trial >= {1'b0, cur.modulus}) ?
               16'(trial - {1'b0, cur.modulus}) : trial[15:0];
  end

  assign take = avail && (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      result_value <= 16'd0;
      plain_char   <= 8'd0;
      bad_symbol   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (avail) begin
            cur <= job;
            if (job.bad || job.modulus == 16'd0) begin
              acc   <= 16'd0;
              state <= S_FINISH;
            end else begin
              num   <= {job.base, 16'd0};
              rem   <= 16'd0;
              rcnt  <= 5'd15;
              op    <= OP_BASE;
              state <= S_RED;
            end
          end
        end
        S_PROD: begin
          num   <= (op == OP_MUL) ? 32'(acc) * 32'(base) : 32'(acc) * 32'(acc);
          rem   <= 16'd0;
          rcnt  <= 5'd31;
          state <= S_RED;
        end
        S_RED: begin
          rem  <= rem_next;
          num  <= {num[30:0], 1'b0};
          rcnt <= rcnt - 5'd1;
          if (rcnt == 5'd0) begin
            unique case (op)
              OP_BASE: begin
                base   <= rem_next;
                acc    <= (cur.modulus == 16'd1) ? 16'd0 : 16'd1;
                bitpos <= 4'd15;
                op     <= OP_SQR;
                state  <= S_PROD;
              end
              OP_SQR: begin
                acc <= rem_next;
                if (cur.expo[bitpos]) begin
                  op    <= OP_MUL;
                  state <= S_PROD;
                end else if (bitpos == 4'd0) begin
                  state <= S_FINISH;
                end else begin
                  bitpos <= bitpos - 4'd1;
                  state  <= S_PROD;
                end
              end
              OP_MUL: begin
                acc <= rem_next;
                if (bitpos == 4'd0) begin
                  state <= S_FINISH;
                end else begin
                  bitpos <= bitpos - 4'd1;
                  op     <= OP_SQR;
                  state  <= S_PROD;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_FINISH: begin
          done         <= 1'b1;
          result_value <= acc;
          bad_symbol   <= cur.bad || (cur.kind && acc > 16'(rsalc_pkg::AlphaLen));
          if (!cur.kind || acc > 16'(rsalc_pkg::AlphaLen))
            plain_char <= 8'd0;
          else if (acc == 16'd0)
            plain_char <= rsalc_pkg::CharZero;
          else
            plain_char <= rsalc_pkg::CharA + acc[7:0] - 8'd1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/rsa_letter_cipher.sv @@
// Top level: RSA letter cipher with APB key registers.
//  channel  | signals                                  | handshake
//  request  | kind, letter_code, cipher_in             | start && !busy
//  result   | result_value, plain_char, bad_symbol     | done, one cycle
//  config   | psel penable pwrite paddr pwdata prdata  | APB, pready high
// The back end holds a word while it reduces the base, then runs 16 squarings plus
// one multiply per set exponent bit, each a product and then a bit-serial reduction;
// a non-letter or zero modulus goes straight to the result.
// A two-word queue lets requests enter while the back end works; busy is high
// while the queue is full. Results cannot be held off.
// Reset is synchronous: clear the queue, load keys 33, 3 and 7.
module rsa_letter_cipher #(
  parameter int MOD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [7:0]  letter_code,
  input  logic [15:0] cipher_in,
  output logic        done,
  output logic [15:0] result_value,
  output logic [7:0]  plain_char,
  output logic        bad_symbol,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] modulus;
  logic [15:0] public_exponent;
  logic [15:0] private_exponent;
  rsalc_pkg::reg_idx_t ridx;
  rsalc_pkg::job_t  fjob;
  rsalc_pkg::job_t  qjob;
  logic q_push;
  logic q_full;
  logic q_ne;
  logic take;

  assign pready = 1'b1;
  assign ridx = (paddr[1:0] != 2'd0) ? rsalc_pkg::REG_NONE :
                rsalc_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus          <= 16'd33;
      public_exponent  <= 16'd3;
      private_exponent <= 16'd7;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        rsalc_pkg::REG_MODULUS: modulus          <= pwdata[15:0];
        rsalc_pkg::REG_PUB_EXP: public_exponent  <= pwdata[15:0];
        rsalc_pkg::REG_PRV_EXP: private_exponent <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      rsalc_pkg::REG_MODULUS: prdata = {16'd0, modulus};
      rsalc_pkg::REG_PUB_EXP: prdata = {16'd0, public_exponent};
      rsalc_pkg::REG_PRV_EXP: prdata = {16'd0, private_exponent};
      default:                prdata = 32'd0;
    endcase
  end

  rsalc_front #(.MOD_BITS(MOD_BITS)) u_front (
    .kind(kind), .letter_code(letter_code), .cipher_in(cipher_in),
    .modulus(modulus), .public_exponent(public_exponent),
    .private_exponent(private_exponent), .job(fjob)
  );

  assign busy   = q_full;
  assign q_push = start && !q_full;

  rsalc_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .din(fjob), .pop(take),
    .dout(qjob), .not_empty(q_ne), .full(q_full)
  );

  rsalc_back u_back (
    .clk(clk), .rst(rst), .avail(q_ne), .job(qjob), .take(take),
    .done(done), .result_value(result_value), .plain_char(plain_char),
    .bad_symbol(bad_symbol)
  );

  a_char_ok: assert property (@(posedge clk) disable iff (rst)
    done && !bad_symbol && plain_char != 8'd0 |-> result_value <= 16'd26)
    else $error("char without valid index");
  a_bad_char: assert property (@(posedge clk) disable iff (rst)
    done && bad_symbol |-> plain_char == 8'd0)
    else $error("bad symbol with char");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done longer than one cycle");

endmodule
